@@ hw/rtl/hft_pkg.sv @@
// hft_pkg: shared types, constants and the arctangent table for the track heading core.
// No dependencies; every other file in hw/rtl uses it by scoped names.
`default_nettype none

package hft_pkg;

   localparam int IO_COORD_W = 32;   // coordinate field width on the request channel
   localparam int HEADING_W  = 16;   // heading field width on the response channel
   localparam int ACC_W      = 36;   // angle accumulator, signed, 32 fraction bits
   localparam int ACC_FRAC   = 32;
   localparam int ATAN_IDX_W = 5;    // table holds 24 entries

   localparam logic signed [ACC_W-1:0] PI_ACC      = 36'sd13493037705;
   localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 36'sd6746518852;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_ITER,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT_HEAD,
      ST_EMIT_LAST,
      ST_EMIT_LONE
   } hft_state_type;

   typedef enum logic [1:0] {
      SRC_FOLD,
      SRC_HEAD,
      SRC_ZERO
   } hft_src_type;

   typedef struct packed {
      logic        take;      // item accepted: store point, load segment deltas
      logic        pre;       // quarter-turn pre-rotation
      logic        iter;      // one micro-rotation
      logic        round;     // round accumulator to output scale
      logic        fold;      // fold into [-pi, pi], keep heading
      logic        out_load;  // load the output register
      hft_src_type out_src;
      logic        out_last;
   } hft_cmd_type;

   typedef struct packed {
      logic out_free;
   } hft_status_type;

   // atan(2^-i) with 32 fraction bits
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 36'sd3373259426;
         5'd1:    val = 36'sd1991351318;
         5'd2:    val = 36'sd1052175346;
         5'd3:    val = 36'sd534100635;
         5'd4:    val = 36'sd268086748;
         5'd5:    val = 36'sd134174063;
         5'd6:    val = 36'sd67103403;
         5'd7:    val = 36'sd33553749;
         5'd8:    val = 36'sd16777131;
         5'd9:    val = 36'sd8388597;
         5'd10:   val = 36'sd4194303;
         5'd11:   val = 36'sd2097152;
         5'd12:   val = 36'sd1048576;
         5'd13:   val = 36'sd524288;
         5'd14:   val = 36'sd262144;
         5'd15:   val = 36'sd131072;
         5'd16:   val = 36'sd65536;
         5'd17:   val = 36'sd32768;
         5'd18:   val = 36'sd16384;
         5'd19:   val = 36'sd8192;
         5'd20:   val = 36'sd4096;
         5'd21:   val = 36'sd2048;
         5'd22:   val = 36'sd1024;
         5'd23:   val = 36'sd512;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hft_req_if.sv @@
// hft_req_if: request channel carrying one track point per item.
// Depends on hft_pkg for the coordinate width.
`default_nettype none

interface hft_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [hft_pkg::IO_COORD_W-1:0]  x_pos;
   logic signed [hft_pkg::IO_COORD_W-1:0]  y_pos;
   logic                                   final_point;

   modport source (output valid, x_pos, y_pos, final_point, input ready);
   modport sink   (input valid, x_pos, y_pos, final_point, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hft_rsp_if.sv @@
// hft_rsp_if: response channel carrying one heading per item.
// Depends on hft_pkg for the heading width.
`default_nettype none

interface hft_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [hft_pkg::HEADING_W-1:0]  heading;
   logic                                  end_of_track;

   modport source (output valid, heading, end_of_track, input ready);
   modport sink   (input valid, heading, end_of_track, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/heading_from_track_points_core.sv @@
// heading_from_track_points_core: top level joining the sequencer and the datapath.
// Depends on hft_pkg, hft_req_if, hft_rsp_if, hft_ctrl and hft_datapath.
//
//   channel   direction  payload                          item
//   req_ch    in         x_pos, y_pos, final_point        one track point
//   rsp_ch    out        heading, end_of_track            one segment heading
//
// A point with a predecessor passes, after acceptance, through one pre-rotation, one reused
// micro-rotation per cycle for CORDIC_ITERATIONS steps, a rounding and a fold step; the fold
// loads the result, and a final point also emits its end-of-track item before the next is taken.
// A first point is only stored; a lone point moves to an emit state that loads a zero heading.
// Reset (synchronous) clears the sequencer, the track state and the output valid.
// The result sits in an output register; a full register holds the sequencer until taken.
`default_nettype none

module heading_from_track_points_core #(
   parameter int COORD_WIDTH       = 32,
   parameter int CORDIC_ITERATIONS = 16,
   parameter int ANGLE_FRAC_BITS   = 13
) (
   input wire logic  clock,
   input wire logic  reset,
   hft_req_if.sink   req_ch,
   hft_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(CORDIC_ITERATIONS);

   hft_pkg::hft_cmd_type    cmd;
   hft_pkg::hft_status_type status;
   logic [IDX_W-1:0]        idx;

   hft_ctrl #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .IDX_W             (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .final_point (req_ch.final_point),
      .req_ready   (req_ch.ready),
      .status      (status),
      .cmd         (cmd),
      .idx         (idx)
   );

   hft_datapath #(
      .COORD_WIDTH     (COORD_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .IDX_W           (IDX_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .idx          (idx),
      .status       (status),
      .x_pos        (req_ch.x_pos),
      .y_pos        (req_ch.y_pos),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .heading      (rsp_ch.heading),
      .end_of_track (rsp_ch.end_of_track)
   );

   // a pending result is never overwritten
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register loaded while an item is still pending");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.pre, cmd.iter, cmd.round, cmd.fold}))
      else $error("more than one datapath step commanded");

   a_pre_iter: assert property (@(posedge clock) disable iff (reset)
      cmd.pre |=> cmd.iter && (idx == '0))
      else $error("micro-rotations do not start at step zero after pre-rotation");

   a_round_fold: assert property (@(posedge clock) disable iff (reset)
      cmd.round |=> cmd.fold)
      else $error("fold does not follow rounding");

endmodule

`default_nettype wire

@@ hw/rtl/hft_ctrl.sv @@
// hft_ctrl: sequencer for the heading core; track state, iteration count, output scheduling.
// Depends on hft_pkg (state, command and status types).
`default_nettype none

module hft_ctrl #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int IDX_W             = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    final_point,
   output      logic                    req_ready,
   input  wire hft_pkg::hft_status_type status,
   output      hft_pkg::hft_cmd_type    cmd,
   output      logic [IDX_W-1:0]        idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_ITERATIONS - 1);

   hft_pkg::hft_state_type state_ff, state_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   fin_ff, fin_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hft_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (have_prev_ff) begin
                  state_in = hft_pkg::ST_PRE;
               end else if (final_point) begin
                  state_in = hft_pkg::ST_EMIT_LONE;
               end
            end
         end
         hft_pkg::ST_PRE: begin
            state_in = hft_pkg::ST_ITER;
         end
         hft_pkg::ST_ITER: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = hft_pkg::ST_ROUND;
            end
         end
         hft_pkg::ST_ROUND: begin
            state_in = hft_pkg::ST_FOLD;
         end
         hft_pkg::ST_FOLD: begin
            if (!status.out_free) begin
               state_in = hft_pkg::ST_EMIT_HEAD;
            end else if (fin_ff) begin
               state_in = hft_pkg::ST_EMIT_LAST;
            end else begin
               state_in = hft_pkg::ST_IDLE;
            end
         end
         hft_pkg::ST_EMIT_HEAD: begin
            if (status.out_free) begin
               state_in = fin_ff ? hft_pkg::ST_EMIT_LAST : hft_pkg::ST_IDLE;
            end
         end
         hft_pkg::ST_EMIT_LAST, hft_pkg::ST_EMIT_LONE: begin
            if (status.out_free) begin
               state_in = hft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hft_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.out_src  = hft_pkg::SRC_FOLD;
      case (state_ff)
         hft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         hft_pkg::ST_PRE: begin
            cmd.pre = 1'b1;
         end
         hft_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
         end
         hft_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         hft_pkg::ST_FOLD: begin
            cmd.fold     = 1'b1;
            cmd.out_load = status.out_free;
            cmd.out_src  = hft_pkg::SRC_FOLD;
         end
         hft_pkg::ST_EMIT_HEAD: begin
            cmd.out_load = status.out_free;
            cmd.out_src  = hft_pkg::SRC_HEAD;
         end
         hft_pkg::ST_EMIT_LAST: begin
            cmd.out_load = status.out_free;
            cmd.out_src  = hft_pkg::SRC_HEAD;
            cmd.out_last = 1'b1;
         end
         hft_pkg::ST_EMIT_LONE: begin
            cmd.out_load = status.out_free;
            cmd.out_src  = hft_pkg::SRC_ZERO;
            cmd.out_last = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // track and counter registers
   always_comb begin
      have_prev_in = have_prev_ff;
      fin_in       = fin_ff;
      cnt_in       = cnt_ff;
      if (cmd.take) begin
         have_prev_in = !final_point;   // a final point closes the track
         fin_in       = final_point;
      end
      if (cmd.pre) begin
         cnt_in = '0;
      end else if (cmd.iter) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hft_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         fin_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         fin_ff       <= fin_in;
         cnt_ff       <= cnt_in;
      end
   end

   assign idx = cnt_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hft_datapath.sv @@
// hft_datapath: previous point, segment deltas, shared CORDIC micro-rotation, rounding, fold
// and the output register. Depends on hft_pkg (types, constants, arctangent table).
`default_nettype none

module hft_datapath #(
   parameter int COORD_WIDTH     = 32,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int IDX_W           = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire hft_pkg::hft_cmd_type                  cmd,
   input  wire logic [IDX_W-1:0]                      idx,
   output      hft_pkg::hft_status_type               status,
   input  wire logic signed [hft_pkg::IO_COORD_W-1:0] x_pos,
   input  wire logic signed [hft_pkg::IO_COORD_W-1:0] y_pos,
   input  wire logic                                  rsp_ready,
   output      logic                                  rsp_valid,
   output      logic signed [hft_pkg::HEADING_W-1:0]  heading,
   output      logic                                  end_of_track
);

   localparam int IO  = hft_pkg::IO_COORD_W;
   localparam int AW  = hft_pkg::ACC_W;
   localparam int HW  = hft_pkg::HEADING_W;
   localparam int AIW = hft_pkg::ATAN_IDX_W;
   localparam int XW  = COORD_WIDTH + 3;      // room for delta, gain and pre-rotation
   localparam int S   = hft_pkg::ACC_FRAC - ANGLE_FRAC_BITS;

   localparam logic signed [AW-1:0] RND    = {{(AW-1){1'b0}}, 1'b1} << (S - 1);
   localparam logic signed [AW-1:0] PI_OUT = (hft_pkg::PI_ACC + RND) >>> S;
   localparam logic signed [AW-1:0] TWO_PI = PI_OUT <<< 1;

   logic signed [COORD_WIDTH-1:0] cx, cy;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [XW-1:0]          x_ff, x_in, y_ff, y_in, xs, ys, dx, dy;
   logic signed [AW-1:0]          z_ff, z_in, hr_ff, hr_in, folded, atan;
   logic                          zero_ff, zero_in;
   logic signed [HW-1:0]          head_ff, head_in, fold_val;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [HW-1:0]          heading_ff, heading_in;
   logic                          eot_ff, eot_in;

   // coordinates of COORD_WIDTH bits taken from the 32-bit fields
   if (COORD_WIDTH <= IO) begin : g_narrow
      assign cx = x_pos[COORD_WIDTH-1:0];
      assign cy = y_pos[COORD_WIDTH-1:0];
   end else begin : g_wide
      assign cx = {{(COORD_WIDTH-IO){1'b0}}, x_pos};
      assign cy = {{(COORD_WIDTH-IO){1'b0}}, y_pos};
   end

   assign dx   = XW'(cx) - XW'(prev_x_ff);
   assign dy   = XW'(cy) - XW'(prev_y_ff);
   assign xs   = x_ff >>> idx;
   assign ys   = y_ff >>> idx;
   assign atan = hft_pkg::atan_entry(AIW'(idx));

   always_comb begin
      if (hr_ff > PI_OUT) begin
         folded = hr_ff - TWO_PI;
      end else if (hr_ff < -PI_OUT) begin
         folded = hr_ff + TWO_PI;
      end else begin
         folded = hr_ff;
      end
      fold_val = zero_ff ? '0 : folded[HW-1:0];
   end

   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      zero_in      = zero_ff;
      hr_in        = hr_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff;
      heading_in   = heading_ff;
      eot_in       = eot_ff;

      if (cmd.take) begin
         prev_x_in = cx;
         prev_y_in = cy;
         x_in      = dx;
         y_in      = dy;
      end

      if (cmd.pre) begin
         zero_in = (x_ff == '0) && (y_ff == '0);
         z_in    = '0;
         if (x_ff[XW-1]) begin
            // left half plane: quarter turn into the right half
            if (!y_ff[XW-1]) begin
               x_in = y_ff;
               y_in = -x_ff;
               z_in = hft_pkg::HALF_PI_ACC;
            end else begin
               x_in = -y_ff;
               y_in = x_ff;
               z_in = -hft_pkg::HALF_PI_ACC;
            end
         end
      end

      if (cmd.iter) begin
         if (!y_ff[XW-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan;
         end
      end

      if (cmd.round) begin
         hr_in = (z_ff + RND) >>> S;
      end

      if (cmd.fold) begin
         head_in = fold_val;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         eot_in       = cmd.out_last;
         case (cmd.out_src)
            hft_pkg::SRC_FOLD: heading_in = fold_val;
            hft_pkg::SRC_HEAD: heading_in = head_ff;
            hft_pkg::SRC_ZERO: heading_in = '0;
            default:           heading_in = '0;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      zero_ff    <= zero_in;
      hr_ff      <= hr_in;
      head_ff    <= head_in;
      heading_ff <= heading_in;
      eot_ff     <= eot_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign heading         = heading_ff;
   assign end_of_track    = eot_ff;

endmodule

`default_nettype wire

@@ bench/tb_heading_from_track_points_core.sv @@
// Testbench for heading_from_track_points_core: streams tracks of points, predicts each
// segment heading with a CORDIC model of its own and checks every response item in order.
// Depends on hft_pkg, hft_req_if, hft_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb_heading_from_track_points_core;

   localparam int    CORDIC_STEPS  = 16;
   localparam int    ANGLE_FRAC    = 13;
   localparam int    ACC_FRAC_BITS = 32;
   localparam int    ROUND_SHIFT   = ACC_FRAC_BITS - ANGLE_FRAC;
   localparam longint PI_Q32       = 64'sd13493037705;
   localparam longint HALF_PI_Q32  = 64'sd6746518852;
   localparam int    POINT_TARGET  = 1100;
   localparam int    TAIL_CYCLES   = 40;
   localparam int    RUN_LIMIT     = 400000;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               fin;
   } track_point_type;

   typedef struct {
      logic signed [hft_pkg::HEADING_W-1:0] heading;
      logic                                 last;
   } heading_item_type;

   logic clock;
   logic reset;

   hft_req_if req_ch ();
   hft_rsp_if rsp_ch ();

   heading_from_track_points_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // atan(2^-i), 32 fraction bits
   longint atan_steps [16] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
      64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
      64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072
   };

   track_point_type  pending_points [$];
   heading_item_type expected_headings [$];

   longint track_prev_x;
   longint track_prev_y;
   bit     track_open;

   int  points_total;
   int  points_accepted;
   int  mismatch_count;
   int  cycle_count;
   bit  req_fire;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic bit hold_off_roll();
      return !(cycle_count >= 3000 && cycle_count < 7000) && ($urandom_range(0, 99) < 18);
   endfunction

   function automatic logic signed [31:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic logic signed [15:0] segment_heading(input longint dx, input longint dy);
      longint cx, cy, ang, xs, ys, rounded, pi_q;
      if (dx == 0 && dy == 0)
         return 16'sd0;
      cx  = dx;
      cy  = dy;
      ang = 0;
      // quarter turn into the right half plane
      if (dx < 0) begin
         if (dy >= 0) begin
            cx  = dy;
            cy  = -dx;
            ang = HALF_PI_Q32;
         end else begin
            cx  = -dy;
            cy  = dx;
            ang = -HALF_PI_Q32;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx  = cx + ys;
            cy  = cy - xs;
            ang = ang + atan_steps[i];
         end else begin
            cx  = cx - ys;
            cy  = cy + xs;
            ang = ang - atan_steps[i];
         end
      end
      rounded = (ang + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      pi_q    = (PI_Q32 + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (rounded > pi_q)
         rounded = rounded - 2 * pi_q;
      else if (rounded < -pi_q)
         rounded = rounded + 2 * pi_q;
      return rounded[15:0];
   endfunction

   function automatic void take_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                      input logic fin);
      heading_item_type item;
      if (track_open) begin
         item.heading = segment_heading(longint'(x) - track_prev_x, longint'(y) - track_prev_y);
         item.last    = 1'b0;
         expected_headings.insert(expected_headings.size(), item);
         if (fin) begin
            item.last = 1'b1;
            expected_headings.insert(expected_headings.size(), item);
         end
      end else if (fin) begin
         item.heading = '0;
         item.last    = 1'b1;
         expected_headings.insert(expected_headings.size(), item);
      end
      if (fin) begin
         track_open   = 1'b0;
         track_prev_x = 0;
         track_prev_y = 0;
      end else begin
         track_open   = 1'b1;
         track_prev_x = longint'(x);
         track_prev_y = longint'(y);
      end
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endfunction

   function automatic void add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                     input logic fin);
      track_point_type p;
      p.x   = x;
      p.y   = y;
      p.fin = fin;
      pending_points.insert(pending_points.size(), p);
   endfunction

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // request side: note accepted points and predict their headings
   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         points_accepted <= points_accepted + 1;
         take_point(req_ch.x_pos, req_ch.y_pos, req_ch.final_point);
      end
   end

   // point driver
   always @(negedge clock) begin
      track_point_type p;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (pending_points.size() != 0 && !hold_off_roll()) begin
            p = pending_points.pop_front();
            req_ch.x_pos       <= p.x;
            req_ch.y_pos       <= p.y;
            req_ch.final_point <= p.fin;
            req_ch.valid       <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && !hold_off_roll();
   end

   // response checker
   always @(posedge clock) begin
      heading_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_headings.size() == 0) begin
            log_mismatch($sformatf("unexpected heading item: heading %0d last %0b",
                                   rsp_ch.heading, rsp_ch.end_of_track));
         end else begin
            want = expected_headings.pop_front();
            if (want.heading !== rsp_ch.heading || want.last !== rsp_ch.end_of_track)
               log_mismatch($sformatf("heading mismatch: expected %0d last %0b, got %0d last %0b",
                                      want.heading, want.last, rsp_ch.heading,
                                      rsp_ch.end_of_track));
         end
      end
   end

   initial begin
      logic signed [31:0] px, py;
      int                 track_len, mode, dx, dy;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.x_pos       = '0;
      req_ch.y_pos       = '0;
      req_ch.final_point = 1'b0;
      rsp_ch.ready       = 1'b0;
      track_open         = 1'b0;
      track_prev_x       = 0;
      track_prev_y       = 0;
      points_accepted    = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      req_fire           = 1'b0;

      // lone point, then a track walking round every axis and quadrant
      add_point(32'sd5, 32'sd7, 1'b1);
      add_point(32'sd0, 32'sd0, 1'b0);
      add_point(32'sd0, 32'sd0, 1'b0);         // zero segment
      add_point(32'sd100, 32'sd0, 1'b0);
      add_point(32'sd100, 32'sd100, 1'b0);
      add_point(32'sd0, 32'sd100, 1'b0);       // due west, lands on pi
      add_point(32'sd0, 32'sd0, 1'b0);
      add_point(-32'sd50, -32'sd50, 1'b0);
      add_point(COORD_MIN, COORD_MAX, 1'b0);
      add_point(COORD_MAX, COORD_MIN, 1'b0);   // widest deltas
      add_point(COORD_MIN, COORD_MIN, 1'b0);
      add_point(COORD_MAX, COORD_MAX, 1'b1);
      add_point(COORD_MAX, 32'sd0, 1'b0);
      add_point(COORD_MIN, 32'sd1, 1'b1);      // just above due west
      add_point(32'sd3, 32'sd3, 1'b0);
      add_point(32'sd3, 32'sd3, 1'b1);         // repeated final point
      add_point(32'sd0, 32'sd0, 1'b0);
      add_point(-32'sd7, -32'sd1, 1'b0);       // just below due west
      add_point(-32'sd7, 32'sd0, 1'b1);
      add_point(COORD_MIN, COORD_MIN, 1'b1);

      while (pending_points.size() < POINT_TARGET) begin
         track_len = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(2, 12);
         px = '0;
         py = '0;
         for (int k = 0; k < track_len; k++) begin
            mode = $urandom_range(0, 99);
            if ((k == 0 && mode < 80) || (k != 0 && mode < 30)) begin
               px = $urandom;
               py = $urandom;
            end else if (k == 0 || mode < 40) begin
               px = corner_value();
               py = corner_value();
            end else begin
               dx = int'($urandom_range(0, 2000)) - 1000;
               dy = int'($urandom_range(0, 2000)) - 1000;
               if (mode < 50)
                  dx = 0;
               else if (mode < 60)
                  dy = 0;
               else if (mode < 63) begin
                  dx = 0;
                  dy = 0;
               end
               px = px + dx;
               py = py + dy;
            end
            add_point(px, py, k == track_len - 1);
         end
      end
      points_total = pending_points.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_points.size() != 0 || points_accepted != points_total ||
             expected_headings.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_headings.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/hft_pkg.sv
hw/rtl/hft_req_if.sv
hw/rtl/hft_rsp_if.sv
hw/rtl/hft_ctrl.sv
hw/rtl/hft_datapath.sv
hw/rtl/heading_from_track_points_core.sv
bench/tb_heading_from_track_points_core.sv
